// ----- hdl/wcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted cache replacement package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wcr_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SIZE_W  = 23;
  localparam int unsigned KEEP_W  = 16;
  localparam int unsigned TOTAL_W = 28;
  localparam int unsigned CAP_W   = 24;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned COST_W  = SIZE_W + TIME_W;
  localparam int unsigned KEEP1_W = KEEP_W + 1;
  localparam int unsigned PROD_W  = COST_W + KEEP1_W;
  localparam int unsigned KB_SHIFT = 10;

  localparam logic [BYTES_W:0]  KB_ROUND  = (BYTES_W+1)'(10'h3ff);
  localparam logic [SIZE_W-1:0] SIZE_BIAS = SIZE_W'(5);
  localparam logic [KEEP_W-1:0] KEEP_MAX  = {KEEP_W{1'b1}};
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(ENTRIES - 1);

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KEEP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNKEEP = 3'd4;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             load_in;
    logic             clr_find;
    logic             find_chk;
    logic             clr_best;
    logic             cost_mul;
    logic             cost_xm;
    logic             cost_cmp;
    logic             evict_sel;
    logic             evict_best;
    logic             write_entry;
    logic             emit_done;
  } wcr_ctl_t;

  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic hit;
    logic sel_valid;
    logic need_evict;
    logic best_found;
    logic out_free;
  } wcr_sts_t;

endpackage

// ----- hdl/wcr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted cache replacement controller
// Sequences table scans, cost scans, evictions and result transfers.
// ----------------------------------------------------------------------------
module wcr_ctrl
  import wcr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wcr_sts_t sts_i,
  output wcr_ctl_t ctl_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FRD  = 4'd1;
  localparam logic [3:0] ST_FCHK = 4'd2;
  localparam logic [3:0] ST_DISP = 4'd3;
  localparam logic [3:0] ST_EVS  = 4'd4;
  localparam logic [3:0] ST_BCHK = 4'd5;
  localparam logic [3:0] ST_CRD  = 4'd6;
  localparam logic [3:0] ST_CMUL = 4'd7;
  localparam logic [3:0] ST_CXM  = 4'd8;
  localparam logic [3:0] ST_CCMP = 4'd9;
  localparam logic [3:0] ST_CEND = 4'd10;
  localparam logic [3:0] ST_WR   = 4'd11;
  localparam logic [3:0] ST_DONE = 4'd12;

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.idx  = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in  = 1'b1;
          ctl_o.clr_find = 1'b1;
          idx_d          = '0;
          state_d        = ST_FRD;
        end
      end
      ST_FRD: state_d = ST_FCHK;
      ST_FCHK: begin
        ctl_o.find_chk = 1'b1;
        if (idx_q == IDX_LAST) begin
          state_d = ST_DISP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_FRD;
        end
      end
      ST_DISP: begin
        if (sts_i.is_insert) begin
          state_d = sts_i.sel_valid ? ST_EVS : ST_BCHK;
        end else if (sts_i.is_remove && sts_i.hit) begin
          state_d = ST_EVS;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_EVS: begin
        if (sts_i.out_free) begin
          ctl_o.evict_sel = 1'b1;
          state_d = sts_i.is_insert ? ST_BCHK : ST_DONE;
        end
      end
      ST_BCHK: begin
        if (sts_i.need_evict) begin
          ctl_o.clr_best = 1'b1;
          idx_d          = '0;
          state_d        = ST_CRD;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_CRD: state_d = ST_CMUL;
      ST_CMUL: begin
        ctl_o.cost_mul = 1'b1;
        state_d        = ST_CXM;
      end
      ST_CXM: begin
        ctl_o.cost_xm = 1'b1;
        state_d       = ST_CCMP;
      end
      ST_CCMP: begin
        ctl_o.cost_cmp = 1'b1;
        if (idx_q == IDX_LAST) begin
          state_d = ST_CEND;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CRD;
        end
      end
      ST_CEND: begin
        if (!sts_i.best_found) begin
          state_d = ST_WR;
        end else if (sts_i.out_free) begin
          ctl_o.evict_best = 1'b1;
          state_d          = ST_BCHK;
        end
      end
      ST_WR: begin
        if (sts_i.out_free) begin
          ctl_o.write_entry = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.emit_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- hdl/wcr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted cache replacement datapath
// Entry table, find and cost scan registers, budget total and result register.
// ----------------------------------------------------------------------------
module wcr_dp
  import wcr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wcr_ctl_t           ctl_i,
  output wcr_sts_t           sts_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [BYTES_W-1:0] file_bytes_i,
  input  logic [TIME_W-1:0]  now_i,
  input  logic               owned_i,
  input  logic               cfg_valid_i,
  input  logic [CAP_W-1:0]   cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               kind_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               hit_o,
  output logic               delete_file_o,
  output logic [SIZE_W-1:0]  evicted_kb_o,
  output logic [TOTAL_W-1:0] used_kb_o,
  output logic               last_o
);

  logic [CAP_W-1:0]   cap_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [SIZE_W-1:0]  size_q;
  logic [TIME_W-1:0]  now_q;
  logic               owned_q;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [ENTRIES-1:0] valid_q;

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic              own_mem  [ENTRIES];
  logic [TIME_W-1:0] last_mem [ENTRIES];
  logic [SIZE_W-1:0] size_mem [ENTRIES];
  logic [KEEP_W-1:0] keep_mem [ENTRIES];

  logic              rd_valid_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic              rd_own_q;
  logic [TIME_W-1:0] rd_last_q;
  logic [SIZE_W-1:0] rd_size_q;
  logic [KEEP_W-1:0] rd_keep_q;

  logic              hfound_q, vfree_q, vany_q;
  logic [IDX_W-1:0]  hslot_q, vslot_q;
  logic [KEEP_W-1:0] hkeep_q, vkeep_q;
  logic [SIZE_W-1:0] hsize_q, vsize_q;
  logic              howned_q, vowned_q;
  logic [TIME_W-1:0] vlast_q;

  logic               celig_q, bfound_q;
  logic [COST_W-1:0]  cn_q, bn_q;
  logic [KEEP1_W-1:0] ck1_q, bk1_q;
  logic [SIZE_W-1:0]  csize_q, bsize_q;
  logic               cowned_q, bowned_q;
  logic [IDX_W-1:0]   bslot_q;
  logic [PROD_W-1:0]  lhs_q, rhs_q;

  logic               out_valid_q;
  logic               emit;
  logic               known, hit_known;
  logic [IDX_W-1:0]   sel_slot, wr_slot;
  logic [SIZE_W-1:0]  sel_size;
  logic               sel_owned;
  logic [CAP_W-1:0]   need;
  logic [KEEP_W-1:0]  keep_new, keep_wdata;
  logic               keep_we, last_we;
  logic [TIME_W-1:0]  age;
  logic [BYTES_W:0]   bytes_round;

  assign known     = (cmd_q <= CMD_UNKEEP);
  assign hit_known = known && hfound_q;
  assign sel_slot  = hfound_q ? hslot_q  : vslot_q;
  assign sel_size  = hfound_q ? hsize_q  : vsize_q;
  assign sel_owned = hfound_q ? howned_q : vowned_q;
  assign need      = (CAP_W'(size_q) > cap_q) ? cap_q : CAP_W'(size_q);
  assign emit      = ctl_i.evict_sel | ctl_i.evict_best | ctl_i.write_entry
                   | ctl_i.emit_done;
  assign age       = now_q - rd_last_q;
  assign bytes_round = {1'b0, file_bytes_i} + KB_ROUND;

  assign sts_o.is_insert  = (cmd_q == CMD_INSERT);
  assign sts_o.is_remove  = (cmd_q == CMD_REMOVE);
  assign sts_o.hit        = hfound_q;
  assign sts_o.sel_valid  = hfound_q | ~vfree_q;
  assign sts_o.need_evict = (cap_q != '0) &&
      (({1'b0, total_q} + (TOTAL_W+1)'(need)) > (TOTAL_W+1)'(cap_q));
  assign sts_o.best_found = bfound_q;
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    if (cmd_q == CMD_KEEP) begin
      keep_new = (hkeep_q == KEEP_MAX) ? hkeep_q : hkeep_q + 1'b1;
    end else begin
      keep_new = (hkeep_q == '0) ? hkeep_q : hkeep_q - 1'b1;
    end
  end

  always_comb begin
    priority if (ctl_i.evict_best) begin
      wr_slot = bslot_q;
    end else if (ctl_i.emit_done) begin
      wr_slot = hslot_q;
    end else begin
      wr_slot = sel_slot;
    end
  end

  assign keep_we = ctl_i.evict_sel | ctl_i.evict_best | ctl_i.write_entry
                 | (ctl_i.emit_done && hit_known &&
                    (cmd_q == CMD_KEEP || cmd_q == CMD_UNKEEP));
  assign keep_wdata = ctl_i.emit_done ? keep_new : '0;
  assign last_we    = ctl_i.write_entry
                    | (ctl_i.emit_done && hit_known && cmd_q == CMD_LOOKUP);

  always_comb begin
    priority if (ctl_i.evict_sel) begin
      total_d = total_q - TOTAL_W'(sel_size);
    end else if (ctl_i.evict_best) begin
      total_d = total_q - TOTAL_W'(bsize_q);
    end else if (ctl_i.write_entry) begin
      total_d = total_q + TOTAL_W'(size_q);
    end else begin
      total_d = total_q;
    end
  end

  // Table storage
  always_ff @(posedge clk_i) begin
    if (ctl_i.write_entry) begin
      key_mem[wr_slot]  <= key_q;
      own_mem[wr_slot]  <= owned_q;
      size_mem[wr_slot] <= size_q;
    end
    if (last_we) begin
      last_mem[wr_slot] <= now_q;
    end
    if (keep_we) begin
      keep_mem[wr_slot] <= keep_wdata;
    end
    rd_key_q  <= key_mem[ctl_i.idx];
    rd_own_q  <= own_mem[ctl_i.idx];
    rd_last_q <= last_mem[ctl_i.idx];
    rd_size_q <= size_mem[ctl_i.idx];
    rd_keep_q <= keep_mem[ctl_i.idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      total_q    <= '0;
      cap_q      <= '0;
    end else begin
      rd_valid_q <= valid_q[ctl_i.idx];
      total_q    <= total_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (ctl_i.evict_sel || ctl_i.evict_best) begin
        valid_q[wr_slot] <= 1'b0;
      end else if (ctl_i.write_entry) begin
        valid_q[wr_slot] <= 1'b1;
      end
    end
  end

  // Command capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q   <= command_i;
      key_q   <= key_i;
      size_q  <= SIZE_W'(bytes_round >> KB_SHIFT);
      now_q   <= now_i;
      owned_q <= owned_i;
    end
  end

  // Find scan: key hit and replacement victim
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hfound_q <= 1'b0;
      vfree_q  <= 1'b0;
      vany_q   <= 1'b0;
    end else if (ctl_i.clr_find) begin
      hfound_q <= 1'b0;
      vfree_q  <= 1'b0;
      vany_q   <= 1'b0;
    end else if (ctl_i.find_chk) begin
      if (rd_valid_q && rd_key_q == key_q && !hfound_q) begin
        hfound_q <= 1'b1;
      end
      if (!vfree_q) begin
        if (!rd_valid_q) begin
          vfree_q <= 1'b1;
        end else begin
          vany_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.find_chk) begin
      if (rd_valid_q && rd_key_q == key_q && !hfound_q) begin
        hslot_q  <= ctl_i.idx;
        hkeep_q  <= rd_keep_q;
        hsize_q  <= rd_size_q;
        howned_q <= rd_own_q;
      end
      if (!vfree_q) begin
        if (!rd_valid_q) begin
          vslot_q <= ctl_i.idx;
        end else if (!vany_q || rd_keep_q < vkeep_q ||
                     (rd_keep_q == vkeep_q && rd_last_q < vlast_q)) begin
          vslot_q  <= ctl_i.idx;
          vkeep_q  <= rd_keep_q;
          vlast_q  <= rd_last_q;
          vsize_q  <= rd_size_q;
          vowned_q <= rd_own_q;
        end
      end
    end
  end

  // Cost scan: (size+5)*age/(1+keep), compared by cross products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bfound_q <= 1'b0;
      celig_q  <= 1'b0;
    end else begin
      if (ctl_i.cost_mul) begin
        celig_q <= rd_valid_q && (now_q > rd_last_q);
      end
      if (ctl_i.clr_best) begin
        bfound_q <= 1'b0;
      end else if (ctl_i.cost_cmp && celig_q && (!bfound_q || lhs_q > rhs_q)) begin
        bfound_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cost_mul) begin
      cn_q     <= COST_W'(rd_size_q + SIZE_BIAS) * COST_W'(age);
      ck1_q    <= KEEP1_W'(rd_keep_q) + 1'b1;
      csize_q  <= rd_size_q;
      cowned_q <= rd_own_q;
    end
    if (ctl_i.cost_xm) begin
      lhs_q <= PROD_W'(cn_q) * PROD_W'(bk1_q);
      rhs_q <= PROD_W'(bn_q) * PROD_W'(ck1_q);
    end
    if (ctl_i.cost_cmp && celig_q && (!bfound_q || lhs_q > rhs_q)) begin
      bslot_q  <= ctl_i.idx;
      bn_q     <= cn_q;
      bk1_q    <= ck1_q;
      bsize_q  <= csize_q;
      bowned_q <= cowned_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      used_kb_o <= total_d;
      if (ctl_i.evict_sel || ctl_i.evict_best) begin
        kind_o        <= KIND_EVICT;
        slot_o        <= SLOT_W'(wr_slot);
        hit_o         <= 1'b0;
        delete_file_o <= ctl_i.evict_sel ? sel_owned : bowned_q;
        evicted_kb_o  <= ctl_i.evict_sel ? sel_size : bsize_q;
        last_o        <= 1'b0;
      end else begin
        kind_o        <= KIND_DONE;
        slot_o        <= ctl_i.write_entry ? SLOT_W'(sel_slot) :
                         (hit_known ? SLOT_W'(hslot_q) : '0);
        hit_o         <= ctl_i.write_entry ? hfound_q : hit_known;
        delete_file_o <= 1'b0;
        evicted_kb_o  <= '0;
        last_o        <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.evict_sel, ctl_i.evict_best, ctl_i.write_entry, ctl_i.emit_done}))
    else $error("more than one result in a cycle");

  a_best_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.evict_best |-> (bfound_q && valid_q[bslot_q]))
    else $error("budget eviction without an eligible entry");

  a_sel_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.evict_sel |-> valid_q[sel_slot])
    else $error("eviction of an empty slot");

endmodule

// ----- hdl/weighted_cache_replacement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted cache replacement
// Keyed 32-slot entry table with a KB budget and cost-weighted eviction.
// ----------------------------------------------------------------------------
// A command is taken only while the block is idle. Every command first scans
// the table slot by slot through a single read port. Lookup, keep and unkeep
// then give their done result; a remove that hits reports its eviction first.
// Insert adds, for each budget eviction, a cost scan that for every slot does
// one read, one cost multiply, one pair of cross multiplies and one compare.
// Each eviction report and the final done result wait for the output register
// to be free, so a stalled result side holds the sequence.
module weighted_cache_replacement
  import wcr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [BYTES_W-1:0] file_bytes_i,
  input  logic [TIME_W-1:0]  now_i,
  input  logic               owned_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               hit_o,
  output logic               delete_file_o,
  output logic [SIZE_W-1:0]  evicted_kb_o,
  output logic [TOTAL_W-1:0] used_kb_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_data_i
);

  wcr_ctl_t ctl;
  wcr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  wcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  wcr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (command_i),
    .key_i         (key_i),
    .file_bytes_i  (file_bytes_i),
    .now_i         (now_i),
    .owned_i       (owned_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .slot_o        (slot_o),
    .hit_o         (hit_o),
    .delete_file_o (delete_file_o),
    .evicted_kb_o  (evicted_kb_o),
    .used_kb_o     (used_kb_o),
    .last_o        (last_o)
  );

endmodule
